### design/mbds_pkg.sv
// mbds_pkg: field widths, stream packing and register map of the debounce scanner
// no dependencies; imported by multi_button_debounce_scanner
package mbds_pkg;

    // field widths
    localparam int TIME_W       = 32;
    localparam int LEVEL_W      = 8;
    localparam int DEBOUNCE_W   = 16;
    localparam int BUTTON_NUM_W = 4;

    // stream widths (tdata filled up to whole bytes)
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;
    localparam int M_TDATA_USED_W = BUTTON_NUM_W + 1 + TIME_W + LEVEL_W;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_DEBOUNCE_TIME  = 1'b0,
        REG_BUTTON_PRESENT = 1'b1
    } reg_index_t;

    // reset values of the registers
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [LEVEL_W-1:0]    PRESENT_RESET  = 8'hFF;

endpackage

### design/multi_button_debounce_scanner.sv
// multi_button_debounce_scanner: lockout-time debouncer for up to eight buttons
// depends on mbds_pkg for widths, stream packing and the register map
//
// One poll beat (millisecond time plus one level bit per button) is taken every
// clock cycle while the result side takes beats, and gives exactly one result beat,
// presented on the result channel from the result register behind the input register.
// The poll is captured in an input register; from there the eight age checks
// (32-bit wrapping subtract and compare against debounce_time) run in parallel,
// a priority pick selects the lowest-numbered qualifying button, and the result
// register and the per-button stable level and change time are written at the
// same edge, so the next poll already sees the updated state. Throughput is one
// poll per cycle as long as the result side takes beats; a stalled result side
// holds one finished beat and one pending poll before s_tready drops.
// Registers: debounce_time at byte address 0, button_present at byte address 4.
module multi_button_debounce_scanner #(
    parameter int BUTTONS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // poll channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] current_time, [39:32] levels
    input  logic [mbds_pkg::S_TDATA_W-1:0]    s_tdata,
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [3:0] button, [4] pressed, [36:5] event_time, [44:37] stable_mask, rest zero
    output logic [mbds_pkg::M_TDATA_W-1:0]    m_tdata,
    // [0] event_valid
    output logic                              m_tuser,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mbds_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mbds_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mbds_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import mbds_pkg::*;

    // buttons that have a present bit and a level bit
    localparam int SCAN = (BUTTONS < LEVEL_W) ? BUTTONS : LEVEL_W;

    // configuration registers
    logic [DEBOUNCE_W-1:0] debounce_time_reg;
    logic [LEVEL_W-1:0]    button_present_reg;
    reg_index_t            cfg_index;
    logic                  cfg_write;

    // input stage
    logic                  in_valid_reg;
    logic [TIME_W-1:0]     in_time_reg;
    logic [LEVEL_W-1:0]    in_levels_reg;

    // per-button state
    logic                  stable_level_reg [BUTTONS];
    logic [TIME_W-1:0]     last_change_reg  [BUTTONS];

    // result stage
    logic                  out_valid_reg;
    logic                  out_event_reg;
    logic [BUTTON_NUM_W-1:0] out_button_reg;
    logic                  out_pressed_reg;
    logic [TIME_W-1:0]     out_time_reg;
    logic [LEVEL_W-1:0]    out_mask_reg;

    // scan logic
    logic                  s_fire;
    logic                  advance;
    logic                  load;
    logic [LEVEL_W-1:0]    stable_vec;
    logic [LEVEL_W-1:0]    qualify;
    logic [LEVEL_W-1:0]    pick_vec;
    logic [BUTTON_NUM_W-1:0] pick_num;
    logic                  found;
    logic                  pick_level;
    logic [LEVEL_W-1:0]    mask_next;
    logic [TIME_W-1:0]     age [SCAN];

    // register write and read
    assign pready    = 1'b1;
    assign cfg_index = reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_index)
            REG_DEBOUNCE_TIME:  prdata = {{(APB_DATA_W-DEBOUNCE_W){1'b0}}, debounce_time_reg};
            REG_BUTTON_PRESENT: prdata = {{(APB_DATA_W-LEVEL_W){1'b0}}, button_present_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_time_reg  <= DEBOUNCE_RESET;
            button_present_reg <= PRESENT_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_DEBOUNCE_TIME:  debounce_time_reg  <= pwdata[DEBOUNCE_W-1:0];
                REG_BUTTON_PRESENT: button_present_reg <= pwdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: the result register frees up, the input stage moves on
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;
    assign load     = in_valid_reg && advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_time_reg   <= s_tdata[TIME_W-1:0];
            in_levels_reg <= s_tdata[TIME_W +: LEVEL_W];
        end
    end

    // per-button candidate check: present, differs, old enough
    always_comb begin
        stable_vec = '0;
        qualify    = '0;
        for (int i = 0; i < SCAN; i++) begin
            stable_vec[i] = stable_level_reg[i];
            age[i]        = in_time_reg - last_change_reg[i];
            qualify[i]    = button_present_reg[i]
                         && (in_levels_reg[i] != stable_level_reg[i])
                         && (age[i] >= {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_time_reg});
        end
    end

    // lowest-numbered qualifying button wins
    always_comb begin
        pick_vec = '0;
        pick_num = '0;
        for (int i = SCAN - 1; i >= 0; i--) begin
            if (qualify[i]) begin
                pick_vec = '0;
                pick_vec[i] = 1'b1;
                pick_num = BUTTON_NUM_W'(i + 1);
            end
        end
        found      = |pick_vec;
        pick_level = |(pick_vec & in_levels_reg);
        mask_next  = (stable_vec & ~pick_vec) | (in_levels_reg & pick_vec);
    end

    // state write-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BUTTONS; i++) begin
                stable_level_reg[i] <= 1'b0;
                last_change_reg[i]  <= '0;
            end
        end else if (load) begin
            for (int i = 0; i < SCAN; i++) begin
                if (pick_vec[i]) begin
                    stable_level_reg[i] <= in_levels_reg[i];
                    last_change_reg[i]  <= in_time_reg;
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_event_reg   <= found;
            out_button_reg  <= pick_num;
            out_pressed_reg <= pick_level;
            out_time_reg    <= found ? in_time_reg : '0;
            out_mask_reg    <= mask_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_event_reg;
    assign m_tdata  = {{(M_TDATA_W-M_TDATA_USED_W){1'b0}},
                       out_mask_reg, out_time_reg, out_pressed_reg, out_button_reg};

    // at most one button changes level per poll
    assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> ($countones(stable_vec ^ $past(stable_vec)) <= 1))
        else $error("more than one stable level changed in one poll");

    // no accepted change means the stable state holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !found) |=> (stable_vec == $past(stable_vec)))
        else $error("stable state changed without an event");

    // event beats carry a button number, quiet beats carry zeros in the event fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_event_reg) |-> (out_button_reg != '0))
        else $error("event without a button number");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_event_reg) |->
            (out_button_reg == '0 && !out_pressed_reg && out_time_reg == '0))
        else $error("quiet result carries event fields");

    // the reported mask matches the stored state
    assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (out_mask_reg == stable_vec))
        else $error("result mask differs from stored state");

endmodule

### verif/testbench.sv
// testbench for multi_button_debounce_scanner: poll beats go in, result beats are checked
// against a cycle-free debounce predictor kept in step with every accepted poll
// depends on mbds_pkg (stream widths, register indexes) and the scanner rtl
`timescale 1ns / 100ps

module testbench;
    import mbds_pkg::*;

    localparam logic [15:0] DEBOUNCE_AT_RESET = 16'd50;
    localparam logic [7:0]  PRESENT_AT_RESET  = 8'hFF;
    localparam int          HOLD_OFF_CYCLES   = 150;

    // expected result of one poll
    typedef struct packed {
        logic        event_valid;
        logic [3:0]  button;
        logic        pressed;
        logic [31:0] event_time;
        logic [7:0]  stable_mask;
    } poll_result_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // [31:0] current_time, [39:32] levels
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [3:0] button, [4] pressed, [36:5] event_time, [44:37] stable_mask, rest zero
    logic [M_TDATA_W-1:0]  m_tdata;
    // [0] event_valid
    logic                  m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor state and register copies
    logic [7:0]   stable_q;
    logic [31:0]  change_time_q [8];
    logic [15:0]  debounce_cfg;
    logic [7:0]   present_cfg;

    poll_result_t pending_results [$];
    int           error_count = 0;

    // sender pacing
    bit           sender_gaps = 1'b0;
    int           burst_left  = 0;

    // receiver hold-off request, written by the test sequence only
    int           hold_req_cnt = 0;

    // receiver's own bookkeeping
    int           rx_hold_seen  = 0;
    int           rx_hold_left  = 0;
    int           rx_mode       = 0;
    int           rx_phase_left = 0;
    logic [15:0]  rx_pattern    = 16'hA5C3;

    multi_button_debounce_scanner DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // debounce decision for one poll, updates the predictor state
    function automatic poll_result_t debounce_poll(input logic [31:0] poll_time,
                                                   input logic [7:0]  poll_levels);
        poll_result_t r;
        logic [31:0]  age;
        r = '0;
        for (int b = 0; b < 8; b++) begin
            age = poll_time - change_time_q[b];
            if (!r.event_valid && present_cfg[b] && poll_levels[b] != stable_q[b]
                && age >= {16'h0000, debounce_cfg}) begin
                stable_q[b]      = poll_levels[b];
                change_time_q[b] = poll_time;
                r.event_valid    = 1'b1;
                r.button         = 4'(b + 1);
                r.pressed        = poll_levels[b];
                r.event_time     = poll_time;
            end
        end
        r.stable_mask = stable_q;
        return r;
    endfunction

    task automatic report_field(input string name, input logic [31:0] want_v,
                                input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            error_count++;
        end
    endtask

    // offer one poll beat, keep valid high for a following beat unless a gap is due
    task automatic send_poll(input logic [31:0] poll_time, input logic [7:0] poll_levels);
        s_tvalid <= 1'b1;
        s_tdata  <= {poll_levels, poll_time};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(debounce_poll(poll_time, poll_levels));
        if (sender_gaps) begin
            if (burst_left == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    // stop offering and let every outstanding result come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // register read, after which the bus is left idle
    task automatic read_reg(input reg_index_t idx, input logic [31:0] want_v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        report_field(idx == REG_DEBOUNCE_TIME ? "prdata debounce_time" :
                     "prdata button_present", want_v, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // register write, mirrored into the predictor, then read back
    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_DEBOUNCE_TIME) begin
            debounce_cfg = value[15:0];
            @(posedge aclk);
            read_reg(idx, {16'h0000, debounce_cfg});
        end else begin
            present_cfg = value[7:0];
            @(posedge aclk);
            read_reg(idx, {24'h000000, present_cfg});
        end
    endtask

    // result check: each beat against the oldest expectation
    always @(posedge aclk) begin : result_check
        poll_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no poll waiting: tdata 0x%0h", m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                report_field("event_valid", 32'(want.event_valid), 32'(m_tuser));
                report_field("button", 32'(want.button), 32'(m_tdata[3:0]));
                report_field("pressed", 32'(want.pressed), 32'(m_tdata[4]));
                report_field("event_time", want.event_time, m_tdata[36:5]);
                report_field("stable_mask", 32'(want.stable_mask), 32'(m_tdata[44:37]));
                report_field("tdata padding", 32'h0, 32'(m_tdata[M_TDATA_W-1:45]));
            end
        end
    end

    // receiver: phases of its own stall patterns, plus requested hold-offs
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else if (hold_req_cnt != rx_hold_seen) begin
            rx_hold_seen = hold_req_cnt;
            rx_hold_left = HOLD_OFF_CYCLES;
            m_tready <= 1'b0;
        end else begin
            if (rx_phase_left == 0) begin
                rx_mode       = $urandom_range(0, 3);
                rx_phase_left = $urandom_range(20, 200);
                rx_pattern    = 16'($urandom);
            end
            rx_phase_left--;
            case (rx_mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= ($urandom_range(0, 3) != 0);
                end
                2: begin
                    m_tready <= ($urandom_range(0, 2) == 0);
                end
                default: begin
                    rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
                    m_tready <= rx_pattern[0];
                end
            endcase
        end
    end

    // reset values readable before anything is written
    task automatic test_register_reset();
        read_reg(REG_DEBOUNCE_TIME, {16'h0000, DEBOUNCE_AT_RESET});
        read_reg(REG_BUTTON_PRESENT, {24'h000000, PRESENT_AT_RESET});
    endtask

    // lockout boundary at the reset debounce time, lowest button wins
    task automatic test_lockout_boundary();
        send_poll(32'd0, 8'h00);
        send_poll(32'd10, 8'h01);
        send_poll(32'd49, 8'h01);
        send_poll(32'd50, 8'h01);
        send_poll(32'd60, 8'hFF);
        send_poll(32'd61, 8'hFF);
        send_poll(32'd99, 8'hFE);
        send_poll(32'd100, 8'hFE);
    endtask

    // wrapping age and time stepping backwards
    task automatic test_time_wrap();
        send_poll(32'hFFFF_FFF0, 8'h80);
        send_poll(32'h0000_0005, 8'h00);
        send_poll(32'h0000_0022, 8'h00);
        send_poll(32'h0000_0010, 8'hFF);
        send_poll(32'hFFFF_FFFF, 8'h00);
    endtask

    // absent buttons are ignored but keep showing in the mask
    task automatic test_absent_buttons();
        drain_results();
        write_reg(REG_BUTTON_PRESENT, 32'h0000_0000);
        send_poll(32'd1000, 8'hFF);
        drain_results();
        write_reg(REG_BUTTON_PRESENT, 32'h0000_005A);
        send_poll(32'd1001, 8'hFF);
        send_poll(32'd1002, 8'hFF);
        send_poll(32'd1003, 8'h00);
    endtask

    // zero debounce locks nothing out, the largest one locks out long
    task automatic test_debounce_extremes();
        drain_results();
        write_reg(REG_BUTTON_PRESENT, 32'h0000_00FF);
        write_reg(REG_DEBOUNCE_TIME, 32'h0000_0000);
        send_poll(32'd2000, 8'h0F);
        send_poll(32'd2000, 8'h0F);
        send_poll(32'd2000, 8'hF0);
        drain_results();
        write_reg(REG_DEBOUNCE_TIME, 32'h0000_FFFF);
        send_poll(32'd2000 + 32'h0000_FFFE, 8'h00);
        send_poll(32'd2000 + 32'h0000_FFFF, 8'h00);
        send_poll(32'd2001 + 32'h0000_FFFF, 8'hFF);
    endtask

    // presses and releases with contact bounce, across several register settings
    task automatic test_bouncing_presses(input int phases, input int polls_per_phase);
        logic [31:0] poll_clock;
        logic [31:0] step_max;
        logic [7:0]  held;
        logic [7:0]  bouncing;
        int          bounce_left;
        int          b;
        poll_clock  = 32'd5000;
        held        = 8'h00;
        bouncing    = 8'h00;
        bounce_left = 0;
        for (int ph = 0; ph < phases; ph++) begin
            drain_results();
            case (ph)
                0: write_reg(REG_DEBOUNCE_TIME, {16'($urandom), 16'h0000});
                1: write_reg(REG_DEBOUNCE_TIME, {16'($urandom), 16'hFFFF});
                2: write_reg(REG_DEBOUNCE_TIME, {16'($urandom), 16'd50});
                3: write_reg(REG_DEBOUNCE_TIME, 32'($urandom_range(1, 20)));
                default: write_reg(REG_DEBOUNCE_TIME, $urandom);
            endcase
            if (ph % 3 == 0)
                write_reg(REG_BUTTON_PRESENT, {24'($urandom), 8'hFF});
            else
                write_reg(REG_BUTTON_PRESENT, $urandom);
            sender_gaps = (ph % 4 != 1);
            step_max    = {16'h0000, debounce_cfg} / 4 + 3;
            for (int n = 0; n < polls_per_phase; n++) begin
                // a new press or release starts bouncing on one button
                if ($urandom_range(0, 7) == 0) begin
                    b           = $urandom_range(0, 7);
                    held[b]     = ~held[b];
                    bouncing[b] = 1'b1;
                    bounce_left = $urandom_range(0, 6);
                end
                if (bounce_left == 0)
                    bouncing = 8'h00;
                else
                    bounce_left--;
                // mostly steady time, now and then a jump or a step back
                case ($urandom_range(0, 63))
                    0:       poll_clock = $urandom;
                    1:       poll_clock = poll_clock - $urandom_range(1, 100);
                    default: poll_clock = poll_clock + $urandom_range(0, step_max);
                endcase
                send_poll(poll_clock, held ^ (bouncing & 8'($urandom)));
            end
        end
    endtask

    // receiver holds off while polls keep coming, so the input side stalls
    task automatic test_result_backpressure();
        logic [31:0] poll_clock;
        drain_results();
        write_reg(REG_DEBOUNCE_TIME, 32'd4);
        write_reg(REG_BUTTON_PRESENT, 32'h0000_00FF);
        sender_gaps  = 1'b0;
        poll_clock   = $urandom;
        hold_req_cnt <= hold_req_cnt + 1;
        for (int n = 0; n < 60; n++) begin
            poll_clock = poll_clock + $urandom_range(0, 6);
            send_poll(poll_clock, 8'($urandom));
        end
    endtask

    // sender waits until every result is back, then goes on
    task automatic test_sender_pause();
        logic [31:0] poll_clock;
        poll_clock  = $urandom;
        sender_gaps = 1'b1;
        for (int n = 0; n < 20; n++) begin
            poll_clock = poll_clock + $urandom_range(0, 8);
            send_poll(poll_clock, 8'($urandom));
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        for (int n = 0; n < 20; n++) begin
            poll_clock = poll_clock + $urandom_range(0, 8);
            send_poll(poll_clock, 8'($urandom));
        end
    endtask

    // unrelated times and levels with random registers
    task automatic test_random_noise(input int polls);
        drain_results();
        write_reg(REG_DEBOUNCE_TIME, $urandom);
        write_reg(REG_BUTTON_PRESENT, $urandom);
        sender_gaps = 1'b1;
        for (int n = 0; n < polls; n++)
            send_poll($urandom, 8'($urandom));
    endtask

    initial begin
        stable_q     = 8'h00;
        debounce_cfg = DEBOUNCE_AT_RESET;
        present_cfg  = PRESENT_AT_RESET;
        for (int b = 0; b < 8; b++)
            change_time_q[b] = 32'h0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_reset();
        test_lockout_boundary();
        test_time_wrap();
        test_absent_buttons();
        test_debounce_extremes();
        test_bouncing_presses(8, 200);
        test_result_backpressure();
        test_sender_pause();
        test_random_noise(300);

        // wait out everything still in flight
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (error_count == 0)
            $display("multi_button_debounce_scanner regression: pass");
        else
            $display("multi_button_debounce_scanner regression: fail");
        $finish;
    end

    // hang guard
    initial begin
        #2000000;
        $display("multi_button_debounce_scanner regression: fail");
        $finish;
    end

endmodule

### files.f
design/mbds_pkg.sv
design/multi_button_debounce_scanner.sv
verif/testbench.sv
